// ===== src/ufold_pkg.sv =====
package ufold_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] LEAD_BYTE   = 8'hC3;
  localparam logic [7:0] A_UML_UPPER = 8'h84;
  localparam logic [7:0] A_UML_LOWER = 8'hA4;
  localparam logic [7:0] O_UML_UPPER = 8'h96;
  localparam logic [7:0] O_UML_LOWER = 8'hB6;
  localparam logic [7:0] U_UML_UPPER = 8'h9C;
  localparam logic [7:0] U_UML_LOWER = 8'hBC;
  localparam logic [7:0] SHARP_S     = 8'h9F;
  localparam logic [7:0] LATIN_FIRST = 8'h80;
  localparam logic [7:0] LATIN_LAST  = 8'h9E;
  localparam logic [7:0] TIMES_SIGN  = 8'h97;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;
  localparam logic [7:0] ASCII_UP_Z  = 8'h5A;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_E = 8'h65;
  localparam logic [7:0] CHAR_O = 8'h6F;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_U = 8'h75;

  // one or two output bytes caused by one input transfer
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
    logic       eos;
  } run_t;

endpackage

// ===== src/ufold_if.sv =====
interface ufold_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ufold_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       last_of_string;

  modport source (output valid, output out_byte, output last_of_run,
                  output last_of_string, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input last_of_string, output ready);
endinterface

// ===== src/ufold_front.sv =====
module ufold_front (
  input  logic            clk,
  input  logic            rst,
  ufold_in_if.sink        raw,
  input  logic            full,
  output logic            push,
  output ufold_pkg::run_t push_data
);
  import ufold_pkg::*;

  logic       lead_pending;
  logic       lead_pending_next;
  logic       accept;
  logic [7:0] b;
  logic       eos;
  logic [7:0] lowered;
  logic       is_upper_latin;
  logic       hold;
  logic       emit;

  assign raw.ready = !full;
  assign accept    = raw.valid && raw.ready;
  assign b         = raw.in_byte;
  assign eos       = raw.end_of_string;

  assign lowered = (b >= ASCII_UP_A && b <= ASCII_UP_Z) ? b + CASE_OFFSET : b;
  assign is_upper_latin = (b >= LATIN_FIRST) && (b <= LATIN_LAST) && (b != TIMES_SIGN);
  assign hold = (b == LEAD_BYTE) && !eos;

  always_comb begin
    push_data.eos    = eos;
    push_data.first  = lowered;
    push_data.second = lowered;
    push_data.two    = 1'b0;
    emit             = 1'b1;
    if (lead_pending) begin
      if (b == A_UML_UPPER || b == A_UML_LOWER) begin
        push_data.first  = CHAR_A;
        push_data.second = CHAR_E;
        push_data.two    = 1'b1;
      end else if (b == O_UML_UPPER || b == O_UML_LOWER) begin
        push_data.first  = CHAR_O;
        push_data.second = CHAR_E;
        push_data.two    = 1'b1;
      end else if (b == U_UML_UPPER || b == U_UML_LOWER) begin
        push_data.first  = CHAR_U;
        push_data.second = CHAR_E;
        push_data.two    = 1'b1;
      end else if (b == SHARP_S) begin
        push_data.first  = CHAR_S;
        push_data.second = CHAR_S;
        push_data.two    = 1'b1;
      end else if (is_upper_latin) begin
        push_data.first  = LEAD_BYTE;
        push_data.second = b + CASE_OFFSET;
        push_data.two    = 1'b1;
      end else if (hold) begin
        // held lead goes out, the new one is held again
        push_data.first = LEAD_BYTE;
      end else begin
        push_data.first = LEAD_BYTE;
        push_data.two   = 1'b1;
      end
    end else if (hold) begin
      emit = 1'b0;
    end
  end

  assign push = accept && emit;

  always_comb begin
    lead_pending_next = lead_pending;
    if (accept) begin
      lead_pending_next = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
    end else begin
      lead_pending <= lead_pending_next;
    end
  end

  a_eos_clears_lead: assert property (@(posedge clk) disable iff (rst)
    accept && eos |=> !lead_pending)
    else $error("lead still held after end of string");

  a_silent_only_on_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !push |-> !lead_pending && hold)
    else $error("transfer dropped without holding a lead");

endmodule

// ===== src/ufold_queue.sv =====
module ufold_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ufold_pkg::run_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output ufold_pkg::run_t head
);
  import ufold_pkg::*;

  run_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign avail = (count != '0);
  assign head  = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !avail))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== src/ufold_back.sv =====
module ufold_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  ufold_pkg::run_t head,
  output logic            pop,
  ufold_out_if.source     folded
);
  import ufold_pkg::*;

  logic phase;
  logic phase_next;
  logic load;

  assign load = avail && (!folded.valid || folded.ready);
  assign pop  = load && (phase || !head.two);

  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = !phase && head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      folded.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        folded.valid <= 1'b1;
      end else if (folded.ready) begin
        folded.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      folded.out_byte       <= phase ? head.second : head.first;
      folded.last_of_run    <= phase || !head.two;
      folded.last_of_string <= (phase || !head.two) && head.eos;
    end
  end

  a_second_needs_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> avail && head.two)
    else $error("second byte pending without a two byte run");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    load && !phase && head.two |=> phase && folded.valid && !folded.last_of_run)
    else $error("first byte of a pair mislabelled");

endmodule

// ===== src/utf8_german_case_fold.sv =====
// Case fold of a UTF-8 byte stream for search: one byte per input transfer, with an
// end-of-string flag. ASCII capitals are lowered, a 0xC3 lead that does not end the
// string is held until the next byte, German umlauts and sharp s become two ASCII
// letters, and other upper-case Latin-1 letters are lowered. The output port delivers
// one byte per cycle while the receiver is ready, so an input gives one output byte,
// two when it expands, none when it only holds a lead. Input transfers are taken
// every cycle while the two-entry run queue between the classifier and the output
// sequencer has room; a byte is written to the run queue and then to the output
// register before it is offered at the output.
module utf8_german_case_fold (
  input  logic        clk,
  input  logic        rst,
  ufold_in_if.sink    raw,
  ufold_out_if.source folded
);
  import ufold_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic avail;
  run_t push_data;
  run_t head;

  ufold_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ufold_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  ufold_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (avail),
    .head   (head),
    .pop    (pop),
    .folded (folded)
  );

endmodule
